### hdl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types, constants and the reply frame byte table of the ARP responder.
// ----------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

  localparam int MaxFrameBytes = 2048;
  localparam int CountW        = 12;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrW     = $clog2(QueueDepth);
  localparam int ReplyBytes    = 60;
  localparam int ByteIdxW      = 6;

  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [15:0] HwtEth    = 16'h0001;
  localparam logic [15:0] ProtoIpv4 = 16'h0800;
  localparam logic [15:0] OpRequest = 16'h0001;
  localparam logic [15:0] OpReply   = 16'h0002;
  localparam logic [7:0]  MacLen    = 8'd6;
  localparam logic [7:0]  IpLen     = 8'd4;
  localparam logic [CountW-1:0] MinLenM1 = CountW'(59);

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] CfgOwnIp     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnMac    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgResolveIp = 2'd2;

  typedef enum logic {
    KIND_REPLY  = 1'b0,
    KIND_NOTICE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] learned_mac;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] reply_byte(input logic [ByteIdxW-1:0] idx,
                                            input logic [47:0] peer_mac,
                                            input logic [47:0] own_mac,
                                            input logic [31:0] own_ip,
                                            input logic [31:0] peer_ip);
    logic [7:0] b;
    b = 8'h00;
    priority if (idx < 6'd6) begin
      b = peer_mac[8*(5-int'(idx)) +: 8];
    end else if (idx < 6'd12) begin
      b = own_mac[8*(11-int'(idx)) +: 8];
    end else if (idx == 6'd12) begin
      b = EtypeArp[15:8];
    end else if (idx == 6'd13) begin
      b = EtypeArp[7:0];
    end else if (idx == 6'd14) begin
      b = HwtEth[15:8];
    end else if (idx == 6'd15) begin
      b = HwtEth[7:0];
    end else if (idx == 6'd16) begin
      b = ProtoIpv4[15:8];
    end else if (idx == 6'd17) begin
      b = ProtoIpv4[7:0];
    end else if (idx == 6'd18) begin
      b = MacLen;
    end else if (idx == 6'd19) begin
      b = IpLen;
    end else if (idx == 6'd20) begin
      b = OpReply[15:8];
    end else if (idx == 6'd21) begin
      b = OpReply[7:0];
    end else if (idx < 6'd28) begin
      b = own_mac[8*(27-int'(idx)) +: 8];
    end else if (idx < 6'd32) begin
      b = own_ip[8*(31-int'(idx)) +: 8];
    end else if (idx < 6'd38) begin
      b = peer_mac[8*(37-int'(idx)) +: 8];
    end else if (idx < 6'd42) begin
      b = peer_ip[8*(41-int'(idx)) +: 8];
    end else begin
      b = 8'h00;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/arp_responder.sv
// ----------------------------------------------------------------------------
// arp_responder
// ARP responder for Ethernet / IPv4: answers requests for the own address and
// learns the MAC of the resolve address from replies.
// ----------------------------------------------------------------------------
//  port group   dir  beat contents
//  s_axis_*     in   tdata = rx_byte, tlast = frame_last
//  m_axis_*     out  tdata = tx_byte, learned_mac; tuser = kind; tlast = out_last
//  cfg_*        in   we / idx / data register writes, no read-back
//
//  Takes one received byte per cycle. A request match yields a 60-beat reply
//  at one beat per cycle; a reply match yields one notice beat.
//  Jobs wait in a four-entry queue; s_axis_tready drops only while it is full.
//  Output beats come from a register; m_axis_tready low holds the beat.
//  Reset clears the captured header fields, the cache and the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_responder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [7:0] rx_byte
  input  wire logic                          s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [55:0]                        m_axis_tdata_o,  // [7:0] tx_byte, [55:8] learned_mac
  output logic                               m_axis_tuser_o,  // [0] kind
  output logic                               m_axis_tlast_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [arpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [arpr_pkg::CfgDataW-1:0] cfg_data_i
);
  import arpr_pkg::*;

  logic [31:0]   own_ip_q, resolve_ip_q;
  logic [47:0]   own_mac_q;
  job_t          push_job, head_job;
  logic          push, pop, beat;
  queue_status_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q     <= '0;
      own_mac_q    <= '0;
      resolve_ip_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgOwnIp) begin
        own_ip_q <= cfg_data_i[31:0];
      end
      if (cfg_idx_i == CfgOwnMac) begin
        own_mac_q <= cfg_data_i;
      end
      if (cfg_idx_i == CfgResolveIp) begin
        resolve_ip_q <= cfg_data_i[31:0];
      end
    end
  end

  assign s_axis_tready_o = !qstat.full;
  assign beat = s_axis_tvalid_i && s_axis_tready_o;

  arpr_rx_parse u_rx_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .rx_byte_i    (s_axis_tdata_i),
    .frame_last_i (s_axis_tlast_i),
    .own_ip_i     (own_ip_q),
    .resolve_ip_i (resolve_ip_q),
    .job_o        (push_job),
    .job_push_o   (push)
  );

  arpr_job_queue u_job_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (qstat)
  );

  arpr_tx_gen u_tx_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_valid_i   (!qstat.empty),
    .job_pop_o     (pop),
    .own_mac_i     (own_mac_q),
    .own_ip_i      (own_ip_q),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .kind_o        (m_axis_tuser_o),
    .tx_byte_o     (m_axis_tdata_o[7:0]),
    .learned_mac_o (m_axis_tdata_o[55:8]),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

### hdl/arpr_rx_parse.sv
// ----------------------------------------------------------------------------
// arpr_rx_parse
// Front end: counts received bytes, captures the ARP header, judges the frame
// at its last byte, updates the cache and queues a reply or notice job.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_rx_parse (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                beat_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                frame_last_i,
  input  wire logic [31:0]         own_ip_i,
  input  wire logic [31:0]         resolve_ip_i,
  output arpr_pkg::job_t           job_o,
  output logic                     job_push_o
);
  import arpr_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [15:0] etype_q, etype_d, hwt_q, hwt_d, proto_q, proto_d, op_q, op_d;
  logic [7:0]  hws_q, hws_d, pss_q, pss_d;
  logic [47:0] peer_mac_q, peer_mac_d, cache_q, cache_d;
  logic [31:0] peer_ip_q, peer_ip_d, asked_q, asked_d;
  logic        frame_ok, is_notice, is_reply, room;

  assign room = count_q < CountW'(MaxFrameBytes);

  always_comb begin
    count_d    = count_q;
    etype_d    = etype_q;
    hwt_d      = hwt_q;
    proto_d    = proto_q;
    hws_d      = hws_q;
    pss_d      = pss_q;
    op_d       = op_q;
    peer_mac_d = peer_mac_q;
    peer_ip_d  = peer_ip_q;
    asked_d    = asked_q;
    if (beat_i && room) begin
      count_d = count_q + CountW'(1);
      priority if (count_q == CountW'(12) || count_q == CountW'(13)) begin
        etype_d = {etype_q[7:0], rx_byte_i};
      end else if (count_q == CountW'(14) || count_q == CountW'(15)) begin
        hwt_d = {hwt_q[7:0], rx_byte_i};
      end else if (count_q == CountW'(16) || count_q == CountW'(17)) begin
        proto_d = {proto_q[7:0], rx_byte_i};
      end else if (count_q == CountW'(18)) begin
        hws_d = rx_byte_i;
      end else if (count_q == CountW'(19)) begin
        pss_d = rx_byte_i;
      end else if (count_q == CountW'(20) || count_q == CountW'(21)) begin
        op_d = {op_q[7:0], rx_byte_i};
      end else if (count_q >= CountW'(22) && count_q <= CountW'(27)) begin
        peer_mac_d = {peer_mac_q[39:0], rx_byte_i};
      end else if (count_q >= CountW'(28) && count_q <= CountW'(31)) begin
        peer_ip_d = {peer_ip_q[23:0], rx_byte_i};
      end else if (count_q >= CountW'(38) && count_q <= CountW'(41)) begin
        asked_d = {asked_q[23:0], rx_byte_i};
      end else begin
        count_d = count_q + CountW'(1);
      end
    end
    if (beat_i && frame_last_i) begin
      count_d = '0;
    end
  end

  // Header fields end at byte 41; a passing frame ends at byte 59 or later.
  assign frame_ok = etype_q == EtypeArp && count_q >= MinLenM1 && hwt_q == HwtEth &&
                    proto_q == ProtoIpv4 && hws_q == MacLen && pss_q == IpLen;
  assign is_notice = op_q == OpReply && peer_ip_q == resolve_ip_i;
  assign is_reply  = op_q == OpRequest && asked_q == own_ip_i;

  always_comb begin
    cache_d          = cache_q;
    job_push_o       = 1'b0;
    job_o.kind       = KIND_REPLY;
    job_o.learned_mac = cache_q;
    job_o.peer_mac   = peer_mac_q;
    job_o.peer_ip    = peer_ip_q;
    if (beat_i && frame_last_i && frame_ok) begin
      if (is_notice) begin
        cache_d           = peer_mac_q;
        job_o.kind        = KIND_NOTICE;
        job_o.learned_mac = peer_mac_q;
        job_push_o        = 1'b1;
      end else if (is_reply) begin
        job_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      etype_q    <= '0;
      hwt_q      <= '0;
      proto_q    <= '0;
      hws_q      <= '0;
      pss_q      <= '0;
      op_q       <= '0;
      peer_mac_q <= '0;
      peer_ip_q  <= '0;
      asked_q    <= '0;
      cache_q    <= '0;
    end else begin
      count_q    <= count_d;
      etype_q    <= etype_d;
      hwt_q      <= hwt_d;
      proto_q    <= proto_d;
      hws_q      <= hws_d;
      pss_q      <= pss_d;
      op_q       <= op_d;
      peer_mac_q <= peer_mac_d;
      peer_ip_q  <= peer_ip_d;
      asked_q    <= asked_d;
      cache_q    <= cache_d;
    end
  end

endmodule

`default_nettype wire

### hdl/arpr_job_queue.sv
// ----------------------------------------------------------------------------
// arpr_job_queue
// Short FIFO of jobs between the receive parser and the transmit generator.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_job_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire arpr_pkg::job_t       job_i,
  input  wire logic                 pop_i,
  output arpr_pkg::job_t            job_o,
  output arpr_pkg::queue_status_t   status_o
);
  import arpr_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign status_o.full  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign status_o.empty = cnt_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QueuePtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QueuePtrW'(1) : rd_q;
    cnt_d = cnt_q + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/arpr_tx_gen.sv
// ----------------------------------------------------------------------------
// arpr_tx_gen
// Back end: turns the head job into one notice beat or a 60-byte reply frame,
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_tx_gen (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire arpr_pkg::job_t job_i,
  input  wire logic         job_valid_i,
  output logic              job_pop_o,
  input  wire logic [47:0]  own_mac_i,
  input  wire logic [31:0]  own_ip_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic              kind_o,
  output logic [7:0]        tx_byte_o,
  output logic [47:0]       learned_mac_o,
  output logic              out_last_o
);
  import arpr_pkg::*;

  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                valid_q, valid_d, kind_q, kind_d, last_q, last_d;
  logic [7:0]          byte_q, byte_d;
  logic [47:0]         mac_q, mac_d;
  logic                load, at_end;

  assign load   = job_valid_i && (!valid_q || out_ready_i);
  assign at_end = job_i.kind == KIND_NOTICE || idx_q == ByteIdxW'(ReplyBytes - 1);
  assign job_pop_o = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    kind_d  = kind_q;
    byte_d  = byte_q;
    mac_d   = mac_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      kind_d  = job_i.kind;
      mac_d   = job_i.learned_mac;
      last_d  = at_end;
      idx_d   = at_end ? '0 : idx_q + ByteIdxW'(1);
      byte_d  = (job_i.kind == KIND_NOTICE) ? 8'h00 :
                reply_byte(idx_q, job_i.peer_mac, own_mac_i, own_ip_i, job_i.peer_ip);
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    mac_q  <= mac_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign tx_byte_o     = byte_q;
  assign learned_mac_o = mac_q;
  assign out_last_o    = last_q;

endmodule

`default_nettype wire

### hdl/arpr_checker.sv
// ----------------------------------------------------------------------------
// arpr_checker
// Port-level checks of the ARP responder output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [55:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  a_notice_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'h00)
    else $error("notice beat malformed");

  a_reply_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o && !m_axis_tuser_o)
    else $error("reply frame interrupted");

  a_reply_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> $stable(m_axis_tdata_o[55:8]))
    else $error("learned MAC changed within a reply frame");

endmodule

bind arp_responder arpr_checker u_arpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
